// File: sv/joystick_axis_hat_to_button_events_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the joystick event converter
// Shared property shapes used by the port checker.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_HAT_TO_BUTTON_EVENTS_ASSERT_SVH
`define JOYSTICK_AXIS_HAT_TO_BUTTON_EVENTS_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define JAHBE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jahbe: same-cycle check failed");

// Next-cycle implication, quiet while reset is high.
`define JAHBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jahbe: next-cycle check failed");

// Next-cycle implication that also watches the reset cycles.
`define JAHBE_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jahbe: reset check failed");

`endif

// File: sv/jahbe_pkg.sv
// ---------------------------------------------------------------------------
// jahbe_pkg
// Types, constants and codes shared by the joystick event converter.
// ---------------------------------------------------------------------------
package jahbe_pkg;

  // Number of real axes and hats the storage is sized for.
  localparam int AXES    = 8;
  localparam int HATS    = 4;
  localparam int AXIS_IW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int HAT_IW  = (HATS > 1) ? $clog2(HATS) : 1;

  // Depth of the job queue between front and back.
  localparam int FIFO_DEPTH = 4;

  // Percent limit and calibration reset values.
  localparam int                 PCT_MAX                 = 100;
  localparam logic signed [15:0] CAL_LOW_RESET           = -16'sd32767;
  localparam logic signed [15:0] CAL_HIGH_RESET          = 16'sd32767;
  localparam logic [6:0]         DEFAULT_THRESHOLD_RESET = 7'd50;
  localparam logic [3:0]         AXIS_COUNT_RESET        = 4'd8;

  // Division by 100 as multiply by ceil(2^30 / 100), exact below 2^23.
  localparam logic [23:0] DIV100_MUL   = 24'd10737419;
  localparam int          DIV100_SHIFT = 30;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OP_MODE           = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_AXIS_COUNT        = 2'd2;

  // Request codes carried on the input tuser.
  typedef enum logic [2:0] {
    REQ_AXIS   = 3'd0,
    REQ_HAT    = 3'd1,
    REQ_BUTTON = 3'd2,
    REQ_CENTRE = 3'd3,
    REQ_THRESH = 3'd4
  } req_t;

  // Kind of work handed from front to back.
  typedef enum logic [1:0] {
    KIND_AXIS   = 2'd0,
    KIND_HAT    = 2'd1,
    KIND_BUTTON = 2'd2
  } kind_t;

  // One job: a snapshot of everything the back needs for one item.
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         code;
    logic signed [15:0] val;
    logic signed [15:0] old;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] cen;
    logic [6:0]         tn;
    logic [6:0]         tp;
    logic [3:0]         now;
    logic [3:0]         was;
  } job_t;

  // One output event.
  typedef struct packed {
    logic       is_axis;
    logic [7:0] code;
    logic       positive;
    logic       pressed;
  } event_t;

endpackage

// File: sv/jahbe_front.sv
// ---------------------------------------------------------------------------
// jahbe_front
// Accepts input words, applies configuration, keeps per-axis and per-hat
// state, and turns each item that can cause events into a queued job.
// ---------------------------------------------------------------------------
module jahbe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // s_tdata fields from bit 0: item_index[7:0], axis_value[15:0], hat_bits[3:0],
  // button_down, threshold_side, threshold_percent[6:0], threshold_enable, zeros
  input  logic [39:0]       s_tdata,
  // s_tuser fields from bit 0: req_type[2:0]
  input  logic [2:0]        s_tuser,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  output jahbe_pkg::job_t   job,
  output logic              job_push,
  input  logic              q_full
);

  // Configuration registers.
  logic       op_mode;
  logic [6:0] default_threshold;
  logic [3:0] axis_count;

  // Per-axis and per-hat state.
  logic signed [15:0] axis_last  [jahbe_pkg::AXES];
  logic signed [15:0] cal_low    [jahbe_pkg::AXES];
  logic signed [15:0] cal_high   [jahbe_pkg::AXES];
  logic signed [15:0] cal_centre [jahbe_pkg::AXES];
  logic               neg_en     [jahbe_pkg::AXES];
  logic [6:0]         neg_pct    [jahbe_pkg::AXES];
  logic               pos_en     [jahbe_pkg::AXES];
  logic [6:0]         pos_pct    [jahbe_pkg::AXES];
  logic [3:0]         hat_last   [jahbe_pkg::HATS];

  // Input word fields.
  jahbe_pkg::req_t    req;
  logic [7:0]         idx;
  logic signed [15:0] val;
  logic [3:0]         hat_bits;
  logic               button_down;
  logic               side;
  logic [6:0]         pct;
  logic               en;

  logic                           accept;
  logic                           axis_ok;
  logic                           hat_ok;
  logic [jahbe_pkg::AXIS_IW-1:0]  ai;
  logic [jahbe_pkg::HAT_IW-1:0]   hx;

  function automatic logic [6:0] sat_pct(input logic [6:0] p);
    sat_pct = (p > 7'(jahbe_pkg::PCT_MAX)) ? 7'(jahbe_pkg::PCT_MAX) : p;
  endfunction

  assign req         = jahbe_pkg::req_t'(s_tuser);
  assign idx         = s_tdata[7:0];
  assign val         = s_tdata[23:8];
  assign hat_bits    = s_tdata[27:24];
  assign button_down = s_tdata[28];
  assign side        = s_tdata[29];
  assign pct         = s_tdata[36:30];
  assign en          = s_tdata[37];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Range checks and array indexes.
  assign axis_ok = ({4'd0, axis_count} > idx) && (idx < 8'(jahbe_pkg::AXES));
  assign hat_ok  = idx < 8'(jahbe_pkg::HATS);
  assign ai      = idx[jahbe_pkg::AXIS_IW-1:0];
  assign hx      = idx[jahbe_pkg::HAT_IW-1:0];

  // Build the job from the state as it stands before this item.
  always_comb begin
    job      = '0;
    job.kind = jahbe_pkg::KIND_BUTTON;
    job.code = idx;
    job.val  = val;
    job.old  = axis_last[ai];
    job.lo   = cal_low[ai];
    job.hi   = cal_high[ai];
    job.cen  = cal_centre[ai];
    job.tn   = sat_pct(default_threshold);
    job.tp   = sat_pct(default_threshold);
    job.now  = {3'd0, button_down};
    job.was  = '0;
    job_push = 1'b0;
    case (req)
      jahbe_pkg::REQ_AXIS: begin
        job.kind = jahbe_pkg::KIND_AXIS;
        if (!op_mode && neg_en[ai]) begin
          job.tn = sat_pct(neg_pct[ai]);
        end
        if (!op_mode && pos_en[ai]) begin
          job.tp = sat_pct(pos_pct[ai]);
        end
        job_push = accept && axis_ok;
      end
      jahbe_pkg::REQ_HAT: begin
        job.kind = jahbe_pkg::KIND_HAT;
        job.code = 8'({4'd0, axis_count} + {idx[6:0], 1'b0});
        job.now  = hat_bits;
        job.was  = hat_last[hx];
        job_push = accept && hat_ok;
      end
      jahbe_pkg::REQ_BUTTON: begin
        job_push = accept;
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

  // Configuration writes and state updates on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode           <= 1'b0;
      default_threshold <= jahbe_pkg::DEFAULT_THRESHOLD_RESET;
      axis_count        <= jahbe_pkg::AXIS_COUNT_RESET;
      for (int i = 0; i < jahbe_pkg::AXES; i++) begin
        axis_last[i]  <= '0;
        cal_low[i]    <= jahbe_pkg::CAL_LOW_RESET;
        cal_high[i]   <= jahbe_pkg::CAL_HIGH_RESET;
        cal_centre[i] <= '0;
        neg_en[i]     <= 1'b0;
        neg_pct[i]    <= '0;
        pos_en[i]     <= 1'b0;
        pos_pct[i]    <= '0;
      end
      for (int h = 0; h < jahbe_pkg::HATS; h++) begin
        hat_last[h] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          jahbe_pkg::CFG_OP_MODE:           op_mode           <= cfg_data[0];
          jahbe_pkg::CFG_DEFAULT_THRESHOLD: default_threshold <= cfg_data;
          jahbe_pkg::CFG_AXIS_COUNT:        axis_count        <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (req)
          jahbe_pkg::REQ_AXIS: begin
            if (axis_ok) begin
              axis_last[ai] <= val;
              // Calibrate mode widens the recorded extremes.
              if (op_mode) begin
                if (val < cal_low[ai]) begin
                  cal_low[ai] <= val;
                end
                if (val > cal_high[ai]) begin
                  cal_high[ai] <= val;
                end
              end
            end
          end
          jahbe_pkg::REQ_HAT: begin
            if (hat_ok) begin
              hat_last[hx] <= hat_bits;
            end
          end
          jahbe_pkg::REQ_CENTRE: begin
            if (axis_ok) begin
              cal_centre[ai] <= val;
            end
          end
          jahbe_pkg::REQ_THRESH: begin
            if (axis_ok) begin
              if (side) begin
                pos_en[ai]  <= en;
                pos_pct[ai] <= pct;
              end else begin
                neg_en[ai]  <= en;
                neg_pct[ai] <= pct;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/jahbe_fifo.sv
// ---------------------------------------------------------------------------
// jahbe_fifo
// Short job queue that lets the front and the back stall independently.
// ---------------------------------------------------------------------------
module jahbe_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jahbe_pkg::job_t job_in,
  output logic            full,
  input  logic            pop,
  output jahbe_pkg::job_t job_out,
  output logic            valid
);

  localparam int PW = (jahbe_pkg::FIFO_DEPTH > 1) ? $clog2(jahbe_pkg::FIFO_DEPTH) : 1;
  localparam int CW = $clog2(jahbe_pkg::FIFO_DEPTH + 1);

  jahbe_pkg::job_t entries [jahbe_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(jahbe_pkg::FIFO_DEPTH));
  assign valid   = (count != '0);
  assign job_out = entries[rd_ptr];

  // Pointer wrap for any depth.
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(jahbe_pkg::FIFO_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

// File: sv/jahbe_back.sv
// ---------------------------------------------------------------------------
// jahbe_back
// Threshold arithmetic pipeline and event serializer. Takes one job per cycle
// unless stalled, computes crossings and hat edges, and sends events one per word.
// ---------------------------------------------------------------------------
module jahbe_back (
  input  logic            clk,
  input  logic            rst,
  input  jahbe_pkg::job_t q_job,
  input  logic            q_valid,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  // m_tdata fields from bit 0: event_code[7:0], event_positive, event_pressed, zeros
  output logic [15:0]     m_tdata,
  // m_tuser fields from bit 0: event_is_axis
  output logic            m_tuser,
  output logic            m_tlast
);

  // Fields carried down the pipeline.
  typedef struct packed {
    jahbe_pkg::kind_t   kind;
    logic [7:0]         code;
    logic signed [15:0] val;
    logic signed [15:0] old;
    logic signed [15:0] cen;
    logic [3:0]         now;
    logic [3:0]         was;
  } carry_t;

  carry_t             p1;
  logic               p1_valid;
  logic signed [23:0] p1_mn;
  logic signed [23:0] p1_mp;
  carry_t             p2;
  logic               p2_valid;
  logic signed [16:0] p2_qn;
  logic signed [16:0] p2_qp;

  logic signed [16:0] dn;
  logic signed [16:0] dp;
  logic signed [17:0] cen18;
  logic signed [17:0] val18;
  logic signed [17:0] old18;
  logic signed [17:0] thn;
  logic signed [17:0] thp;

  jahbe_pkg::event_t  bundle     [4];
  logic [3:0]         bundle_mask;
  jahbe_pkg::event_t  ser_slot   [4];
  logic [3:0]         ser_mask;
  logic [3:0]         pop_mask;
  jahbe_pkg::event_t  cur;
  logic               ser_ready;
  logic               p2_go;
  logic               en2;
  logic               en1;

  // Truncating division by 100 through a reciprocal multiply.
  function automatic logic signed [16:0] div100(input logic signed [23:0] m);
    logic [22:0] mag;
    logic [46:0] prod;
    logic [15:0] quo;
    mag  = m[23] ? 23'(-m) : m[22:0];
    prod = {24'd0, mag} * {23'd0, jahbe_pkg::DIV100_MUL};
    quo  = prod[jahbe_pkg::DIV100_SHIFT +: 16];
    div100 = m[23] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  endfunction

  // Handshake between stages.
  assign ser_ready = (ser_mask == '0) || (m_tready && (pop_mask == '0));
  assign p2_go     = p2_valid && (ser_ready || (bundle_mask == '0));
  assign en2       = !p2_valid || p2_go;
  assign en1       = !p1_valid || en2;
  assign q_pop     = q_valid && en1;

  // Stage 1: span from centre times percent.
  assign dn = {q_job.lo[15], q_job.lo} - {q_job.cen[15], q_job.cen};
  assign dp = {q_job.hi[15], q_job.hi} - {q_job.cen[15], q_job.cen};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en1) begin
      p1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1.kind <= q_job.kind;
      p1.code <= q_job.code;
      p1.val  <= q_job.val;
      p1.old  <= q_job.old;
      p1.cen  <= q_job.cen;
      p1.now  <= q_job.now;
      p1.was  <= q_job.was;
      p1_mn   <= $signed({{7{dn[16]}}, dn}) * $signed({17'd0, q_job.tn});
      p1_mp   <= $signed({{7{dp[16]}}, dp}) * $signed({17'd0, q_job.tp});
    end
  end

  // Stage 2: divide by 100.
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en2) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p2    <= p1;
      p2_qn <= div100(p1_mn);
      p2_qp <= div100(p1_mp);
    end
  end

  // Thresholds, each kept at least one step beyond the centre.
  always_comb begin
    cen18 = {{2{p2.cen[15]}}, p2.cen};
    val18 = {{2{p2.val[15]}}, p2.val};
    old18 = {{2{p2.old[15]}}, p2.old};
    thn   = {p2_qn[16], p2_qn} + cen18;
    thp   = {p2_qp[16], p2_qp} + cen18;
    if (thn >= cen18) begin
      thn = cen18 - 18'sd1;
    end
    if (thp <= cen18) begin
      thp = cen18 + 18'sd1;
    end
  end

  // Candidate events in output order, with a mask of those that fire.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bundle[k] = '0;
    end
    bundle_mask = '0;
    case (p2.kind)
      jahbe_pkg::KIND_AXIS: begin
        bundle[0]      = '{1'b1, p2.code, 1'b0, (val18 <= thn)};
        bundle_mask[0] = (val18 <= thn) != (old18 <= thn);
        bundle[1]      = '{1'b1, p2.code, 1'b1, (val18 >= thp)};
        bundle_mask[1] = (val18 >= thp) != (old18 >= thp);
      end
      jahbe_pkg::KIND_HAT: begin
        // Up, down, left, right.
        bundle[0]      = '{1'b1, p2.code, 1'b1, p2.now[0]};
        bundle_mask[0] = p2.now[0] != p2.was[0];
        bundle[1]      = '{1'b1, p2.code, 1'b0, p2.now[2]};
        bundle_mask[1] = p2.now[2] != p2.was[2];
        bundle[2]      = '{1'b1, 8'(p2.code + 1'b1), 1'b0, p2.now[3]};
        bundle_mask[2] = p2.now[3] != p2.was[3];
        bundle[3]      = '{1'b1, 8'(p2.code + 1'b1), 1'b1, p2.now[1]};
        bundle_mask[3] = p2.now[1] != p2.was[1];
      end
      jahbe_pkg::KIND_BUTTON: begin
        bundle[0]      = '{1'b0, p2.code, 1'b0, p2.now[0]};
        bundle_mask[0] = 1'b1;
      end
      default: begin
        bundle_mask = '0;
      end
    endcase
  end

  // Serializer: the lowest pending slot goes out first.
  assign pop_mask = ser_mask & (ser_mask - 4'd1);

  always_comb begin
    cur = ser_slot[3];
    for (int k = 3; k >= 0; k--) begin
      if (ser_mask[k]) begin
        cur = ser_slot[k];
      end
    end
  end

  // A new bundle only loads once the last pending event is leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_mask <= '0;
    end else if (p2_go && (bundle_mask != '0)) begin
      ser_mask <= bundle_mask;
    end else if (m_tvalid && m_tready) begin
      ser_mask <= pop_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_go && (bundle_mask != '0)) begin
      for (int k = 0; k < 4; k++) begin
        ser_slot[k] <= bundle[k];
      end
    end
  end

  // Output word.
  assign m_tvalid = (ser_mask != '0);
  assign m_tlast  = (pop_mask == '0);
  assign m_tuser  = cur.is_axis;
  assign m_tdata  = {6'd0, cur.pressed, cur.positive, cur.code};

endmodule

// File: sv/joystick_axis_hat_to_button_events.sv
// ---------------------------------------------------------------------------
// joystick_axis_hat_to_button_events
// Converts joystick axis, hat and button samples into press/release events.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   one sample or control request
// m_*       out        m_tvalid/m_tready   one press/release event, tlast ends item
// cfg_*     in         cfg_we              op_mode, default_threshold, axis_count
//
// A word is accepted every cycle while the four-entry job queue has room.
// An accepted item passes through the job queue, the span and divide stages
// and the event serializer, which sends one event per cycle while m_tready
// is high; a hat item gives up to four events, and an item may give none.
// Reset clears all axis, hat and override state.
// Output stalls fill the queue and then drop s_tready; input gaps never stall
// the output.
// ---------------------------------------------------------------------------
module joystick_axis_hat_to_button_events (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields from bit 0: item_index[7:0], axis_value[15:0], hat_bits[3:0],
  // button_down, threshold_side, threshold_percent[6:0], threshold_enable, zeros
  input  logic [39:0] s_tdata,
  // s_tuser fields from bit 0: req_type[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields from bit 0: event_code[7:0], event_positive, event_pressed, zeros
  output logic [15:0] m_tdata,
  // m_tuser fields from bit 0: event_is_axis
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  jahbe_pkg::job_t front_job;
  jahbe_pkg::job_t head_job;
  logic            job_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // Front: accept, configure, keep state, issue jobs.
  jahbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (front_job),
    .job_push  (job_push),
    .q_full    (q_full)
  );

  // Job queue.
  jahbe_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (front_job),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (head_job),
    .valid   (q_valid)
  );

  // Back: thresholds, edges and event output.
  jahbe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (head_job),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: sv/jahbe_checker.sv
// ---------------------------------------------------------------------------
// jahbe_checker
// Port-level checks on the event output of the joystick event converter.
// ---------------------------------------------------------------------------
`include "joystick_axis_hat_to_button_events_assert.svh"

module jahbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled event stays offered.
  `JAHBE_ASSERT_NEXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid)

  // A stalled event keeps its contents.
  `JAHBE_ASSERT_NEXT(a_word_holds, m_tvalid && !m_tready, $stable({m_tdata, m_tuser, m_tlast}))

  // A button event is always alone for its item and has no direction.
  `JAHBE_ASSERT_NOW(a_button_single, m_tvalid && !m_tuser, m_tlast && !m_tdata[8])

  // Reset leaves no event pending.
  `JAHBE_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !m_tvalid)

endmodule

bind joystick_axis_hat_to_button_events jahbe_checker u_jahbe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the joystick event converter with axis, hat, button and control
// words, predicts every press/release event and compares each received event
// with the oldest one still awaited, across several register settings.
// ---------------------------------------------------------------------------
module testbench;
  import jahbe_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_ITEMS   = 28;
  localparam int PHASES        = 8;

  // Request codes the block does not define.
  localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;

  // Hat direction masks.
  localparam logic [3:0] HAT_UP    = 4'b0001;
  localparam logic [3:0] HAT_RIGHT = 4'b0010;
  localparam logic [3:0] HAT_DOWN  = 4'b0100;
  localparam logic [3:0] HAT_LEFT  = 4'b1000;

  // Input word fields, item_index in the lowest bits.
  typedef struct packed {
    logic               thr_enable;
    logic [6:0]         thr_pct;
    logic               thr_side;
    logic               button_down;
    logic [3:0]         hat_bits;
    logic signed [15:0] axis_value;
    logic [7:0]         item_index;
  } joy_word_t;

  // One predicted event.
  typedef struct packed {
    logic       is_axis;
    logic [7:0] code;
    logic       positive;
    logic       pressed;
    logic       last;
  } joy_event_t;

  // Tracks axis, hat and override state and the events still awaited.
  class joy_event_model;
    logic               op_mode;
    logic [6:0]         dflt_pct;
    logic [3:0]         n_axes;
    logic signed [15:0] axis_prev[AXES];
    logic signed [15:0] cal_min[AXES];
    logic signed [15:0] cal_max[AXES];
    logic signed [15:0] centre[AXES];
    logic [7:0]         neg_ovr[AXES];
    logic [7:0]         pos_ovr[AXES];
    logic [3:0]         hat_prev[HATS];
    joy_event_t         fresh[$];
    joy_event_t         awaited_events[$];
    int                 errors;

    function new();
      op_mode  = 1'b0;
      dflt_pct = DEFAULT_THRESHOLD_RESET;
      n_axes   = AXIS_COUNT_RESET;
      errors   = 0;
      for (int i = 0; i < AXES; i++) begin
        axis_prev[i] = '0;
        cal_min[i]   = CAL_LOW_RESET;
        cal_max[i]   = CAL_HIGH_RESET;
        centre[i]    = '0;
        neg_ovr[i]   = '0;
        pos_ovr[i]   = '0;
      end
      for (int i = 0; i < HATS; i++) hat_prev[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        CFG_OP_MODE:           op_mode  = val[0];
        CFG_DEFAULT_THRESHOLD: dflt_pct = val;
        CFG_AXIS_COUNT:        n_axes   = val[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited_events.size();
    endfunction

    function int clip_pct(logic [6:0] p);
      return (p > PCT_MAX) ? PCT_MAX : int'(p);
    endfunction

    function void note_event(logic is_axis, logic [7:0] code, logic positive,
                             logic pressed);
      joy_event_t e;
      e = '{is_axis: is_axis, code: code, positive: positive, pressed: pressed,
            last: 1'b0};
      fresh.push_back(e);
    endfunction

    function void hat_transition(logic [3:0] now, logic [3:0] was, logic [3:0] mask,
                                 logic [7:0] code, logic positive);
      if ((now & mask) != 0 && (was & mask) == 0) note_event(1'b1, code, positive, 1'b1);
      if ((now & mask) == 0 && (was & mask) != 0) note_event(1'b1, code, positive, 1'b0);
    endfunction

    // Predicts the events for one accepted word; returns 1 if it had any effect.
    function bit take_word(logic [2:0] req, joy_word_t w);
      int         lo, hi, cen, tn, tp, thn, thp, val, old, code_sum;
      logic [7:0] idx;
      logic [7:0] base;
      bit         axis_ok;
      bit         used;
      joy_event_t e;
      idx     = w.item_index;
      axis_ok = (idx < n_axes) && (idx < AXES);
      used    = 1'b1;
      if (req == REQ_AXIS && axis_ok) begin
        lo  = cal_min[idx];
        hi  = cal_max[idx];
        cen = centre[idx];
        val = w.axis_value;
        tn  = clip_pct(dflt_pct);
        tp  = tn;
        // Overrides apply only outside calibrate mode; calibrate widens the range.
        if (!op_mode) begin
          if (neg_ovr[idx][7]) tn = clip_pct(neg_ovr[idx][6:0]);
          if (pos_ovr[idx][7]) tp = clip_pct(pos_ovr[idx][6:0]);
        end else begin
          if (val < lo) cal_min[idx] = w.axis_value;
          if (val > hi) cal_max[idx] = w.axis_value;
        end
        thn = (lo - cen) * tn / PCT_MAX + cen;
        thp = (hi - cen) * tp / PCT_MAX + cen;
        if (thn >= cen) thn = cen - 1;
        if (thp <= cen) thp = cen + 1;
        old = axis_prev[idx];
        if (val <= thn && old > thn)  note_event(1'b1, idx, 1'b0, 1'b1);
        if (val > thn && old <= thn)  note_event(1'b1, idx, 1'b0, 1'b0);
        if (val >= thp && old < thp)  note_event(1'b1, idx, 1'b1, 1'b1);
        if (val < thp && old >= thp)  note_event(1'b1, idx, 1'b1, 1'b0);
        axis_prev[idx] = w.axis_value;
      end else if (req == REQ_HAT && idx < HATS) begin
        code_sum = int'(n_axes) + 2 * int'(idx);
        base     = code_sum[7:0];
        hat_transition(w.hat_bits, hat_prev[idx], HAT_UP, base, 1'b1);
        hat_transition(w.hat_bits, hat_prev[idx], HAT_DOWN, base, 1'b0);
        hat_transition(w.hat_bits, hat_prev[idx], HAT_LEFT, base + 8'd1, 1'b0);
        hat_transition(w.hat_bits, hat_prev[idx], HAT_RIGHT, base + 8'd1, 1'b1);
        hat_prev[idx] = w.hat_bits;
      end else if (req == REQ_BUTTON) begin
        note_event(1'b0, idx, 1'b0, w.button_down);
      end else if (req == REQ_CENTRE && axis_ok) begin
        centre[idx] = w.axis_value;
      end else if (req == REQ_THRESH && axis_ok) begin
        if (w.thr_side) pos_ovr[idx] = w.thr_enable ? {1'b1, w.thr_pct} : 8'h00;
        else            neg_ovr[idx] = w.thr_enable ? {1'b1, w.thr_pct} : 8'h00;
      end else begin
        used = 1'b0;
      end
      // The final event of the word carries the end mark.
      for (int i = 0; i < fresh.size(); i++) begin
        e      = fresh[i];
        e.last = (i == fresh.size() - 1);
        awaited_events.push_back(e);
      end
      fresh.delete();
      return used;
    endfunction

    function void check_event(logic is_axis, logic [7:0] code, logic positive,
                              logic pressed, logic last);
      joy_event_t e;
      if (awaited_events.size() == 0) begin
        $error("event with none awaited: code %0d is_axis %0b", code, is_axis);
        errors++;
        return;
      end
      e = awaited_events.pop_front();
      if (is_axis !== e.is_axis) begin
        $error("event_is_axis: expected %0b, got %0b", e.is_axis, is_axis);
        errors++;
      end
      if (code !== e.code) begin
        $error("event_code: expected %0d, got %0d", e.code, code);
        errors++;
      end
      if (positive !== e.positive) begin
        $error("event_positive: expected %0b, got %0b", e.positive, positive);
        errors++;
      end
      if (pressed !== e.pressed) begin
        $error("event_pressed: expected %0b, got %0b", e.pressed, pressed);
        errors++;
      end
      if (last !== e.last) begin
        $error("event_last: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  joy_event_model sb = new();
  bit             idle_enable;
  bit             hold_req;
  int             cycle_count;

  joystick_axis_hat_to_button_events i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Event checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_event(m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9], m_tlast);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = idle_enable ? pick_gap() : 0;
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  // Offers one word from a falling edge and returns at a falling edge.
  task automatic send_word(input logic [2:0] req, input joy_word_t w, output bit used);
    int gap;
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {2'b00, w};
    do @(posedge clk); while (!s_tready);
    used = sb.take_word(req, w);
    @(negedge clk);
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits until every awaited event has come and the block has gone quiet.
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic joy_word_t make_word(logic [7:0] idx, logic signed [15:0] val,
                                          logic [3:0] hat, logic bdown, logic side,
                                          logic [6:0] pct, logic en);
    joy_word_t w;
    w = '{thr_enable: en, thr_pct: pct, thr_side: side, button_down: bdown,
          hat_bits: hat, axis_value: val, item_index: idx};
    return w;
  endfunction

  // Random word: mostly valid requests on live axes and hats, some noise.
  task automatic pick_item(output logic [2:0] req, output joy_word_t w);
    int r, na, v, kind;
    r  = $urandom_range(0, 99);
    na = (sb.n_axes < AXES) ? int'(sb.n_axes) : AXES;
    w.item_index  = $urandom_range(0, 255);
    w.axis_value  = $urandom_range(0, 65535);
    w.hat_bits    = $urandom_range(0, 15);
    w.button_down = $urandom_range(0, 1);
    w.thr_side    = $urandom_range(0, 1);
    w.thr_pct     = $urandom_range(0, 127);
    w.thr_enable  = $urandom_range(0, 1);
    if (r < 36) begin
      req = REQ_AXIS;
      if (na > 0) w.item_index = $urandom_range(0, na - 1);
      kind = $urandom_range(0, 3);
      if (kind == 1 && na > 0) begin
        v = int'(sb.centre[w.item_index]) + $urandom_range(0, 4000) - 2000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        w.axis_value = v[15:0];
      end else if (kind == 2) begin
        w.axis_value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
    end else if (r < 60) begin
      req = REQ_HAT;
      w.item_index = $urandom_range(0, HATS - 1);
    end else if (r < 72) begin
      req = REQ_BUTTON;
    end else if (r < 80) begin
      req = REQ_CENTRE;
      if (na > 0) w.item_index = $urandom_range(0, na - 1);
      if ($urandom_range(0, 3) != 0) begin
        v = $urandom_range(0, 12000);
        v = v - 6000;
        w.axis_value = v[15:0];
      end
    end else if (r < 92) begin
      req = REQ_THRESH;
      if (na > 0) w.item_index = $urandom_range(0, na - 1);
      if ($urandom_range(0, 3) != 0) w.thr_pct = $urandom_range(0, PCT_MAX);
      if ($urandom_range(0, 4) != 0) w.thr_enable = 1'b1;
    end else if (r < 95) begin
      req = $urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED);
    end else begin
      // Index beyond the live axes or hats.
      case ($urandom_range(0, 3))
        0: req = REQ_AXIS;
        1: req = REQ_CENTRE;
        2: req = REQ_THRESH;
        default: req = REQ_HAT;
      endcase
      if (req == REQ_HAT) w.item_index = $urandom_range(HATS, 255);
      else                w.item_index = $urandom_range(na, 255);
    end
  endtask

  // Main sequence.
  initial begin
    logic [2:0] req;
    joy_word_t  w;
    bit         used;
    int         counted;
    logic       mode;
    logic [6:0] pct;
    logic [3:0] naxes;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_enable = 1'b1;
    hold_req    = 1'b0;
    cycle_count = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset settings.
    send_word(REQ_AXIS, make_word(8'd0, -16'sd32768, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_AXIS, make_word(8'd0, 16'sd32767, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_AXIS, make_word(8'd0, 16'sd0, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_BUTTON, make_word(8'd255, 16'sd0, 4'h0, 1, 0, 7'd0, 0), used);
    send_word(REQ_BUTTON, make_word(8'd0, 16'sd0, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_HAT, make_word(8'd0, 16'sd0, 4'hF, 0, 0, 7'd0, 0), used);
    send_word(REQ_HAT, make_word(8'd0, 16'sd0, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_HAT, make_word(8'd3, 16'sd0, 4'h5, 0, 0, 7'd0, 0), used);
    send_word(REQ_HAT, make_word(8'd4, 16'sd0, 4'hF, 0, 0, 7'd0, 0), used);
    send_word(REQ_HAT, make_word(8'd255, 16'sd0, 4'hF, 0, 0, 7'd0, 0), used);
    // Moved centre with overrides: above-range percent and a zero percent.
    send_word(REQ_CENTRE, make_word(8'd1, 16'sd1000, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_THRESH, make_word(8'd1, 16'sd0, 4'h0, 0, 0, 7'd127, 1), used);
    send_word(REQ_THRESH, make_word(8'd1, 16'sd0, 4'h0, 0, 1, 7'd0, 1), used);
    send_word(REQ_AXIS, make_word(8'd1, 16'sd1001, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_AXIS, make_word(8'd1, -16'sd32767, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_THRESH, make_word(8'd1, 16'sd0, 4'h0, 0, 0, 7'd5, 0), used);
    send_word(REQ_AXIS, make_word(8'd1, 16'sd0, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_AXIS, make_word(8'd7, 16'sd20000, 4'h0, 0, 0, 7'd0, 0), used);
    // Out-of-range indexes and undefined request codes are dropped.
    send_word(REQ_AXIS, make_word(8'd8, 16'sd20000, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_AXIS, make_word(8'd255, -16'sd32768, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_CENTRE, make_word(8'd255, 16'sd5, 4'h0, 0, 0, 7'd0, 0), used);
    send_word(REQ_THRESH, make_word(8'd200, 16'sd0, 4'h0, 0, 1, 7'd10, 1), used);
    send_word(REQ_FIRST_UNUSED, make_word(8'd0, 16'sd0, 4'hF, 1, 0, 7'd0, 0), used);
    send_word(REQ_LAST_UNUSED, make_word(8'd2, 16'sd0, 4'hF, 1, 0, 7'd0, 0), used);
    settle();

    // Random phases, each under its own register settings.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin mode = 1'b0; pct = 7'd0;   naxes = 4'd8;  end
        1: begin mode = 1'b1; pct = 7'd50;  naxes = 4'd8;  end
        2: begin mode = 1'b0; pct = 7'd100; naxes = 4'd5;  end
        3: begin mode = 1'b1; pct = 7'd127; naxes = 4'd15; end
        4: begin mode = 1'b0; pct = 7'd101; naxes = 4'd0;  end
        5: begin mode = 1'b0; pct = 7'd30;  naxes = 4'd1;  end
        default: begin
          mode  = $urandom_range(0, 1);
          pct   = $urandom_range(0, 127);
          naxes = $urandom_range(1, 15);
        end
      endcase
      write_reg(CFG_OP_MODE, {6'd0, mode});
      write_reg(CFG_DEFAULT_THRESHOLD, pct);
      write_reg(CFG_AXIS_COUNT, {3'd0, naxes});
      // One phase runs with no idling on either side.
      idle_enable = (ph != 2);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick_item(req, w);
        send_word(req, w, used);
        if (used) counted++;
      end
      // Long output hold-off while words keep arriving back to back.
      if (ph == 5) begin
        idle_enable = 1'b0;
        hold_req    = 1'b1;
        for (int i = 0; i < 16; i++) begin
          w = make_word($urandom_range(0, 255), 16'sd0, $urandom_range(0, 15),
                        $urandom_range(0, 1), 0, 7'd0, 0);
          send_word((i % 2 == 0) ? REQ_BUTTON : REQ_HAT, w, used);
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
